[src/dmwc_pkg.sv]
// Shared types and constants for the direct-mapped word cache hit probe.
`default_nettype none

package dmwc_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned WADDR_W     = 30;
  localparam int unsigned REGION_W    = 12;
  localparam int unsigned CNT_W       = 48;
  localparam int unsigned NUM_CNT     = 6;
  localparam int unsigned FWD_DEPTH   = 4;
  localparam int unsigned FWD_PTR_W   = 2;

  localparam logic [REGION_W-1:0] REGION_RESET = 12'h801;
  localparam logic [2:0]          WORD_LOAD    = 3'd2;
  localparam logic [3:0]          FULL_MASK    = 4'hF;
  localparam logic [3:0]          NO_MASK      = 4'h0;
  localparam logic                REQ_LOAD     = 1'b0;
  localparam logic                REQ_STORE    = 1'b1;
  localparam logic [CNT_W-1:0]    CNT_MAX      = {CNT_W{1'b1}};

  localparam int unsigned CNT_WLOAD  = 0;
  localparam int unsigned CNT_FWD    = 1;
  localparam int unsigned CNT_LINE   = 2;
  localparam int unsigned CNT_BEYOND = 3;
  localparam int unsigned CNT_OTHER  = 4;
  localparam int unsigned CNT_STORE  = 5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] byte_addr;
    logic [2:0]        load_width_code;
    logic [3:0]        write_mask;
  } req_t;

  typedef struct packed {
    logic             in_region;
    logic             forward_hit;
    logic             line_hit;
    logic             hit_beyond_forward;
    logic [CNT_W-1:0] word_load_count;
    logic [CNT_W-1:0] forward_hit_count;
    logic [CNT_W-1:0] line_hit_count;
    logic [CNT_W-1:0] beyond_forward_count;
    logic [CNT_W-1:0] other_load_count;
    logic [CNT_W-1:0] store_count;
  } rsp_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

`default_nettype wire

[src/dmwc_ifs.sv]
// Valid/ready channel interfaces for access items and result items.
`default_nettype none

interface dmwc_req_if;
  logic           valid;
  logic           ready;
  dmwc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmwc_rsp_if;
  logic           valid;
  logic           ready;
  dmwc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/dmwc_ctrl.sv]
// Controller: clearing sequence, item handshake and result hold.
`default_nettype none

module dmwc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  dmwc_pkg::stat_t stat_i,
  output dmwc_pkg::cmd_t  cmd_o
);
  import dmwc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE) && !out_valid_q;
    cmd_o.clear_wr = (state_q == ST_CLEAR);
    cmd_o.capture  = accept;
    cmd_o.update   = (state_q == ST_LOOK);
    out_valid_d    = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_LOOK) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[src/dmwc_dpath.sv]
// Datapath: tag memory, forward buffer, statistics counters and result register.
`default_nettype none

module dmwc_dpath #(
  parameter int unsigned LINES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmwc_pkg::REGION_W-1:0]     cfg_wdata_i,
  input  dmwc_pkg::req_t                    req_i,
  input  dmwc_pkg::cmd_t                    cmd_i,
  output dmwc_pkg::stat_t                   stat_o,
  output dmwc_pkg::rsp_t                    rsp_o
);
  import dmwc_pkg::*;

  localparam int unsigned IDX_W = $clog2(LINES);
  localparam int unsigned TAG_W = WADDR_W - IDX_W;
  localparam int unsigned ENT_W = TAG_W + 1;

  logic [REGION_W-1:0] region_q;
  logic                type_q;
  logic [WADDR_W-1:0]  wa_q;
  logic [2:0]          f3_q;
  logic [3:0]          mask_q;

  logic [ENT_W-1:0]    mem_q [LINES];
  logic [ENT_W-1:0]    rd_q;
  logic [IDX_W-1:0]    clr_q;

  logic [WADDR_W-1:0]   fwd_addr_q [FWD_DEPTH];
  logic [FWD_DEPTH-1:0] fwd_valid_q;
  logic [FWD_PTR_W-1:0] fwd_ptr_q;

  logic [CNT_W-1:0]     cnt_q [NUM_CNT];
  logic [NUM_CNT-1:0]   bump;

  logic                 flag_region_q, flag_fwd_q, flag_line_q, flag_beyond_q;

  logic                 in_region, is_load, is_store, full_store, part_store;
  logic                 word_load, fhit, probe_hit, lhit, beyond;
  logic [IDX_W-1:0]     idx;
  logic [TAG_W-1:0]     tag;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;

  assign idx        = wa_q[IDX_W-1:0];
  assign tag        = wa_q[WADDR_W-1:IDX_W];
  assign in_region  = (wa_q[WADDR_W-1:WADDR_W-REGION_W] == region_q);
  assign is_load    = in_region && (type_q == REQ_LOAD);
  assign is_store   = in_region && (type_q == REQ_STORE) && (mask_q != NO_MASK);
  assign full_store = is_store && (mask_q == FULL_MASK);
  assign part_store = is_store && (mask_q != FULL_MASK);
  assign word_load  = is_load && (f3_q == WORD_LOAD);
  assign probe_hit  = rd_q[ENT_W-1] && (rd_q[TAG_W-1:0] == tag);
  assign lhit       = word_load && probe_hit;
  assign beyond     = lhit && !fhit;

  always_comb begin
    fhit = 1'b0;
    for (int k = 0; k < FWD_DEPTH; k++) begin
      if (fwd_valid_q[k] && (fwd_addr_q[k] == wa_q)) begin
        fhit = is_load;
      end
    end
  end

  always_comb begin
    bump             = '0;
    bump[CNT_WLOAD]  = word_load;
    bump[CNT_FWD]    = word_load && fhit;
    bump[CNT_LINE]   = lhit;
    bump[CNT_BEYOND] = beyond;
    bump[CNT_OTHER]  = is_load && !word_load;
    bump[CNT_STORE]  = is_store;
  end

  // Memory write port: clearing sweep, fill, or invalidate on partial store hit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {1'b1, tag};
    if (cmd_i.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.update) begin
      if (is_load || full_store) begin
        mem_we = 1'b1;
      end else if (part_store && probe_hit) begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, tag};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      rd_q <= mem_q[req_i.byte_addr[IDX_W+1:2]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q <= req_i.req_type;
      wa_q   <= req_i.byte_addr[ADDR_W-1:2];
      f3_q   <= req_i.load_width_code;
      mask_q <= req_i.write_mask;
    end
    if (cmd_i.update && full_store) begin
      fwd_addr_q[fwd_ptr_q] <= wa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q      <= REGION_RESET;
      clr_q         <= '0;
      fwd_valid_q   <= '0;
      fwd_ptr_q     <= '0;
      flag_region_q <= 1'b0;
      flag_fwd_q    <= 1'b0;
      flag_line_q   <= 1'b0;
      flag_beyond_q <= 1'b0;
      for (int c = 0; c < NUM_CNT; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        region_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.update) begin
        flag_region_q <= is_load || is_store;
        flag_fwd_q    <= fhit;
        flag_line_q   <= lhit;
        flag_beyond_q <= beyond;
        if (full_store) begin
          fwd_valid_q[fwd_ptr_q] <= 1'b1;
          fwd_ptr_q              <= fwd_ptr_q + 1'b1;
        end else if (part_store) begin
          fwd_valid_q <= '0;
        end
        for (int c = 0; c < NUM_CNT; c++) begin
          if (bump[c] && (cnt_q[c] != CNT_MAX)) begin
            cnt_q[c] <= cnt_q[c] + 1'b1;
          end
        end
      end
    end
  end

  assign stat_o.clear_last = &clr_q;

  always_comb begin
    rsp_o.in_region            = flag_region_q;
    rsp_o.forward_hit          = flag_fwd_q;
    rsp_o.line_hit             = flag_line_q;
    rsp_o.hit_beyond_forward   = flag_beyond_q;
    rsp_o.word_load_count      = cnt_q[CNT_WLOAD];
    rsp_o.forward_hit_count    = cnt_q[CNT_FWD];
    rsp_o.line_hit_count       = cnt_q[CNT_LINE];
    rsp_o.beyond_forward_count = cnt_q[CNT_BEYOND];
    rsp_o.other_load_count     = cnt_q[CNT_OTHER];
    rsp_o.store_count          = cnt_q[CNT_STORE];
  end

endmodule

`default_nettype wire

[src/direct_mapped_word_cache_hit_probe.sv]
// Top level of the direct-mapped word cache hit probe.
//
//   channel   dir   handshake      payload
//   req_i     in    valid/ready    req_type, byte_addr, load_width_code, write_mask
//   rsp_o     out   valid/ready    four hit flags and six 48-bit counters
//   cfg       in    cfg_we_i       region_tag (12 bits)
//
// Each item goes through a registered tag memory read, then compare, update and result load.
// A new item is taken only once the previous result has left, so the registered tag
// read and the result hold keep a single item in flight at a time.
// After reset the tag memory is swept clear line by line; req_i.ready stays low meanwhile.
// A stalled result holds in its register until rsp_o.ready.
`default_nettype none

module direct_mapped_word_cache_hit_probe #(
  parameter int unsigned LINES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmwc_pkg::REGION_W-1:0] cfg_wdata_i,
  dmwc_req_if.sink                      req_i,
  dmwc_rsp_if.source                    rsp_o
);
  import dmwc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dmwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dmwc_dpath #(
    .LINES (LINES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_o.data)
  );

`ifndef SYNTH
  a_rsp_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(req_i.valid && req_i.ready, 2))
    else $error("result appeared without an accepted item");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_o.valid && !cmd.update)
    else $error("new item offered while one is in flight");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_wr |-> !req_i.ready)
    else $error("item accepted during tag clear");

  a_beyond_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.hit_beyond_forward |->
      rsp_o.data.line_hit && !rsp_o.data.forward_hit)
    else $error("beyond-forward flag without line hit or with forward hit");
`endif

endmodule

`default_nettype wire

[tb/dmwc_probe_checker.sv]
// Checker for the hit probe: watches both channels, predicts each result item and compares.
`timescale 1ns / 1ps

module dmwc_probe_checker #(
  parameter int unsigned LINES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmwc_pkg::REGION_W-1:0] cfg_wdata_i,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  dmwc_pkg::req_t                req_data_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  dmwc_pkg::rsp_t                rsp_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);
  import dmwc_pkg::*;

  localparam int unsigned IDX_W = $clog2(LINES);

  logic [REGION_W-1:0]  region_q;
  logic [WADDR_W-1:0]   line_tag [LINES];
  logic                 line_ok  [LINES];
  logic [WADDR_W-1:0]   fwd_addr [FWD_DEPTH];
  logic [FWD_DEPTH-1:0] fwd_ok;
  logic [FWD_PTR_W-1:0] fwd_ptr;
  logic [CNT_W-1:0]     tally [NUM_CNT];
  rsp_t                 expected_rsp_q[$];
  int unsigned          fails;

  assign fail_count_o = fails;

  task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_field(input string what, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  function automatic void bump(input int unsigned c);
    if (tally[c] != CNT_MAX) begin
      tally[c] = tally[c] + 1'b1;
    end
  endfunction

  function automatic rsp_t score_access(input req_t a);
    rsp_t               r;
    logic [WADDR_W-1:0] wa;
    logic [IDX_W-1:0]   idx;
    logic               in_rgn;
    logic               probe;
    r      = '0;
    wa     = a.byte_addr[ADDR_W-1:2];
    idx    = wa[IDX_W-1:0];
    in_rgn = a.byte_addr[ADDR_W-1:ADDR_W-REGION_W] == region_q;
    probe  = line_ok[idx] && (line_tag[idx] == (wa >> IDX_W));
    if (in_rgn && a.req_type == REQ_LOAD) begin
      r.in_region = 1'b1;
      for (int k = 0; k < FWD_DEPTH; k++) begin
        if (fwd_ok[k] && fwd_addr[k] == wa) begin
          r.forward_hit = 1'b1;
        end
      end
      if (a.load_width_code == WORD_LOAD) begin
        bump(CNT_WLOAD);
        if (r.forward_hit) begin
          bump(CNT_FWD);
        end
        if (probe) begin
          r.line_hit = 1'b1;
          bump(CNT_LINE);
          if (!r.forward_hit) begin
            r.hit_beyond_forward = 1'b1;
            bump(CNT_BEYOND);
          end
        end
      end else begin
        bump(CNT_OTHER);
      end
      line_ok[idx]  = 1'b1;
      line_tag[idx] = wa >> IDX_W;
    end else if (in_rgn && a.write_mask != NO_MASK) begin
      r.in_region = 1'b1;
      bump(CNT_STORE);
      if (a.write_mask == FULL_MASK) begin
        fwd_addr[fwd_ptr] = wa;
        fwd_ok[fwd_ptr]   = 1'b1;
        fwd_ptr           = fwd_ptr + 1'b1;
        line_ok[idx]      = 1'b1;
        line_tag[idx]     = wa >> IDX_W;
      end else begin
        fwd_ok = '0;
        if (probe) begin
          line_ok[idx] = 1'b0;
        end
      end
    end
    r.word_load_count      = tally[CNT_WLOAD];
    r.forward_hit_count    = tally[CNT_FWD];
    r.line_hit_count       = tally[CNT_LINE];
    r.beyond_forward_count = tally[CNT_BEYOND];
    r.other_load_count     = tally[CNT_OTHER];
    r.store_count          = tally[CNT_STORE];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      region_q = REGION_RESET;
      line_ok  = '{default: 1'b0};
      fwd_ok   = '0;
      fwd_ptr  = '0;
      tally    = '{default: '0};
      expected_rsp_q.delete();
    end else begin
      if (cfg_we_i) begin
        region_q = cfg_wdata_i;
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsp_q.push_back(score_access(req_data_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          flag_mismatch("result with none expected", rsp_data_i.word_load_count, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("in_region", CNT_W'(rsp_data_i.in_region), CNT_W'(want.in_region));
          check_field("forward_hit", CNT_W'(rsp_data_i.forward_hit),
                      CNT_W'(want.forward_hit));
          check_field("line_hit", CNT_W'(rsp_data_i.line_hit), CNT_W'(want.line_hit));
          check_field("hit_beyond_forward", CNT_W'(rsp_data_i.hit_beyond_forward),
                      CNT_W'(want.hit_beyond_forward));
          check_field("word_load_count", rsp_data_i.word_load_count,
                      want.word_load_count);
          check_field("forward_hit_count", rsp_data_i.forward_hit_count,
                      want.forward_hit_count);
          check_field("line_hit_count", rsp_data_i.line_hit_count, want.line_hit_count);
          check_field("beyond_forward_count", rsp_data_i.beyond_forward_count,
                      want.beyond_forward_count);
          check_field("other_load_count", rsp_data_i.other_load_count,
                      want.other_load_count);
          check_field("store_count", rsp_data_i.store_count, want.store_count);
        end
      end
    end
    outstanding_o <= expected_rsp_q.size();
  end

endmodule

[tb/testbench.sv]
// Top of the hit probe testbench: clock, reset, access stimulus, region writes and verdict.
`timescale 1ns / 1ps

module testbench;
  import dmwc_pkg::*;

  localparam int unsigned LINES      = 1024;
  localparam int unsigned PHASE_LEN  = 100;
  localparam int unsigned IDLE_PCT   = 11;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [REGION_W-1:0] cfg_wdata_i;
  logic                steady;
  int unsigned         fail_count;
  int unsigned         outstanding;

  dmwc_req_if req_ch ();
  dmwc_rsp_if rsp_ch ();

  always #5 clk_i = ~clk_i;

  direct_mapped_word_cache_hit_probe #(
    .LINES (LINES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  dmwc_probe_checker #(
    .LINES (LINES)
  ) u_probe_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (req_ch.valid),
    .req_ready_i   (req_ch.ready),
    .req_data_i    (req_ch.data),
    .rsp_valid_i   (rsp_ch.valid),
    .rsp_ready_i   (rsp_ch.ready),
    .rsp_data_i    (rsp_ch.data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic req_t access_item(input logic kind, input logic [ADDR_W-1:0] addr,
                                       input logic [2:0] code, input logic [3:0] mask);
    req_t r;
    r.req_type        = kind;
    r.byte_addr       = addr;
    r.load_width_code = code;
    r.write_mask      = mask;
    return r;
  endfunction

  function automatic req_t random_access(input logic [REGION_W-1:0] rgn);
    req_t r;
    r.byte_addr = {rgn, 8'($urandom_range(0, 3)), 10'($urandom_range(0, 15)),
                   2'($urandom_range(0, 3))};
    if ($urandom_range(99) < 8) begin
      r.byte_addr = $urandom;
    end else if ($urandom_range(99) < 10) begin
      r.byte_addr[ADDR_W-REGION_W-1:0] = 20'($urandom);
    end
    r.req_type        = ($urandom_range(99) < 55) ? REQ_LOAD : REQ_STORE;
    r.load_width_code = 3'($urandom_range(0, 7));
    r.write_mask      = 4'($urandom_range(0, 15));
    if (r.req_type == REQ_LOAD) begin
      if ($urandom_range(99) < 70) begin
        r.load_width_code = WORD_LOAD;
      end
    end else begin
      case ($urandom_range(0, 19))
        0, 1:    r.write_mask = NO_MASK;
        2, 3, 4, 5, 6, 7, 8:
                 r.write_mask = 4'($urandom_range(1, 14));
        default: r.write_mask = FULL_MASK;
      endcase
    end
    return r;
  endfunction

  task automatic push_access(input req_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk_i);
    while (!req_ch.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_region(input logic [REGION_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input logic [REGION_W-1:0] rgn, input int unsigned quiet_len);
    for (int unsigned n = 0; n < PHASE_LEN; n++) begin
      steady <= (n < quiet_len);
      push_access(random_access(rgn));
    end
    steady <= 1'b0;
  endtask

  initial begin
    logic [REGION_W-1:0] rgn;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    steady       <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset region: misses, hits, forwarding, flush, eviction, pointer wrap
    push_access(access_item(REQ_LOAD,  32'h0000_0000, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_STORE, 32'h8010_0000, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0000, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0003, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_STORE, 32'h8010_0010, 3'd0,      FULL_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0010, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0010, 3'd0,      NO_MASK));
    push_access(access_item(REQ_STORE, 32'h8010_0010, 3'd0,      4'h1));
    push_access(access_item(REQ_LOAD,  32'h8010_0010, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_1000, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0000, WORD_LOAD, NO_MASK));
    for (int k = 0; k < 5; k++) begin
      push_access(access_item(REQ_STORE, 32'h8010_0020 + 4 * k, 3'd5, FULL_MASK));
    end
    push_access(access_item(REQ_LOAD,  32'h8010_0020, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h8010_0030, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'h801F_FFFF, 3'd7,      FULL_MASK));
    push_access(access_item(REQ_STORE, 32'h801F_FFFC, 3'd7,      4'hE));
    push_access(access_item(REQ_LOAD,  32'h801F_FFFC, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_STORE, 32'h7FFF_FFFF, WORD_LOAD, 4'h8));
    random_phase(REGION_RESET, 0);

    set_region('0);
    push_access(access_item(REQ_LOAD,  32'h0000_0000, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_STORE, 32'h000F_FFFF, 3'd1,      FULL_MASK));
    push_access(access_item(REQ_LOAD,  32'h000F_FFFC, WORD_LOAD, NO_MASK));
    random_phase('0, 0);

    set_region('1);
    push_access(access_item(REQ_LOAD,  32'hFFFF_FFFF, WORD_LOAD, NO_MASK));
    push_access(access_item(REQ_LOAD,  32'hFFF0_0000, WORD_LOAD, NO_MASK));
    random_phase('1, 60);

    rgn = REGION_W'($urandom_range(0, 4095));
    set_region(rgn);
    random_phase(rgn, 0);

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("direct_mapped_word_cache_hit_probe test passed");
    end else begin
      $display("direct_mapped_word_cache_hit_probe test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("direct_mapped_word_cache_hit_probe test failed");
    $finish;
  end

endmodule

[files.f]
src/dmwc_pkg.sv
src/dmwc_ifs.sv
src/dmwc_ctrl.sv
src/dmwc_dpath.sv
src/direct_mapped_word_cache_hit_probe.sv
tb/dmwc_probe_checker.sv
tb/testbench.sv
